[rtl/core/rds_name_and_text_decoder_macros.svh]
// Assertion macros used by the RDS name and text decoder RTL.
// The macros expect signals named clk and rst_n in the module that uses them.
`ifndef RDS_NAME_AND_TEXT_DECODER_MACROS_SVH
`define RDS_NAME_AND_TEXT_DECODER_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define RDSNTD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define RDSNTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rdsntd_pkg.sv]
// Package for the RDS name and text decoder: widths, codes, types and helpers.
// No dependencies; the interfaces, the top level and the testbench use it.
`timescale 1ns / 1ps

package rdsntd_pkg;

    // Field and storage widths.
    localparam int BLOCK_W    = 16;
    localparam int ERR_W      = 2;
    localparam int NAME_W     = 64;
    localparam int CHAR_W     = 7;
    localparam int TEXT_DEPTH = 64;
    localparam int TEXT_AW    = 6;
    localparam int NAME_CHARS = 8;

    // Configuration port.
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam logic [CFG_AW-1:0] ADDR_MAX_TRUSTED = 3'h0;
    localparam logic [ERR_W-1:0]  MAX_TRUSTED_RESET = 2'd1;

    // Group types and block B fields.
    localparam logic [3:0]         GRP_NAME   = 4'h0;
    localparam logic [3:0]         GRP_TEXT   = 4'h2;
    localparam logic [BLOCK_W-1:0] VER_B_MASK = 16'h0800;
    localparam logic [3:0]         SEG_ALL    = 4'hF;

    // Character codes.
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    // One step of the letter sequencer, handed from the issue stage to the update stage.
    typedef struct packed {
        logic               first;
        logic               fin;
        logic               clear;
        logic               name_upd;
        logic [1:0]         seg;
        logic [7:0]         name_hi;
        logic [7:0]         name_lo;
        logic               text_grp;
        logic               ab_flag;
        logic               letter;
        logic [TEXT_AW-1:0] place;
        logic [CHAR_W-1:0]  shown;
        logic               fwd;
        logic [CHAR_W-1:0]  fwd_val;
    } seq_op_t;

    // Printable characters pass, everything else becomes a space.
    function automatic logic [7:0] to_print(input logic [7:0] c);
        return (c >= CHAR_SPACE && c < CHAR_DEL) ? c : CHAR_SPACE;
    endfunction

    // Radio text character: CR ends the text and is stored as zero.
    function automatic logic [CHAR_W-1:0] text_char(input logic [7:0] c);
        logic [7:0] p;
        p = to_print(c);
        return (c == CHAR_CR) ? '0 : p[CHAR_W-1:0];
    endfunction

endpackage

[rtl/core/rdsntd_if.sv]
// Channel interfaces of the RDS name and text decoder: group items in, result items out.
// Depends on rdsntd_pkg.
`timescale 1ns / 1ps

interface rdsntd_in_if;
    logic                               valid;
    logic                               ready;
    logic                               mode;
    logic                               group_ready;
    logic [rdsntd_pkg::BLOCK_W-1:0]     block_b;
    logic [rdsntd_pkg::BLOCK_W-1:0]     block_c;
    logic [rdsntd_pkg::BLOCK_W-1:0]     block_d;
    logic [rdsntd_pkg::ERR_W-1:0]       errors_b;
    logic [rdsntd_pkg::ERR_W-1:0]       errors_c;
    logic [rdsntd_pkg::ERR_W-1:0]       errors_d;

    modport source (
        output valid, mode, group_ready, block_b, block_c, block_d,
               errors_b, errors_c, errors_d,
        input  ready
    );
    modport sink (
        input  valid, mode, group_ready, block_b, block_c, block_d,
               errors_b, errors_c, errors_d,
        output ready
    );
endinterface

interface rdsntd_out_if;
    logic                               valid;
    logic                               ready;
    logic [rdsntd_pkg::NAME_W-1:0]      station_name;
    logic                               name_changed;
    logic                               text_changed;
    logic                               letter_valid;
    logic [rdsntd_pkg::TEXT_AW-1:0]     letter_position;
    logic [rdsntd_pkg::CHAR_W-1:0]      letter_value;
    logic                               last;

    modport source (
        output valid, station_name, name_changed, text_changed, letter_valid,
               letter_position, letter_value, last,
        input  ready
    );
    modport sink (
        input  valid, station_name, name_changed, text_changed, letter_valid,
               letter_position, letter_value, last,
        output ready
    );
endinterface

[rtl/core/rdsntd_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module rdsntd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port; a read of the address being written sees old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/rds_name_and_text_decoder.sv]
// Top level of the RDS station name and radio text decoder.
// Depends on rdsntd_pkg, rdsntd_if, rdsntd_ram and the assertion macro header.
//
//   Channel   Direction  Handshake               Moves
//   grp       in         valid / ready           one RDS group or clear event per item
//   res       out        valid / ready           one result item per letter, else one
//   APB       in         psel, penable, pwrite   max_trusted_errors register
//
// Each step of an item gives one result: one for name, clear and ignored groups, up to 2 or 4
// for text groups, because the text RAM takes one letter write per cycle unless the output stalls.
// An accepted item passes the issue, update and output stages before its first result appears.
// Reset clears all valid marks of the text at once; there is no clearing pass.
// A stalled output holds the update and issue stages; the next group is taken while
// earlier letters are still in flight.
`timescale 1ns / 1ps
`include "rds_name_and_text_decoder_macros.svh"

module rds_name_and_text_decoder (
    input  logic                          clk,
    input  logic                          rst_n,
    rdsntd_in_if.sink                     grp,
    rdsntd_out_if.source                  res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rdsntd_pkg::CFG_AW-1:0] paddr,
    input  logic [rdsntd_pkg::CFG_DW-1:0] pwdata,
    output logic [rdsntd_pkg::CFG_DW-1:0] prdata,
    output logic                          pready
);

    localparam int AW = rdsntd_pkg::TEXT_AW;
    localparam int CW = rdsntd_pkg::CHAR_W;
    localparam int EW = rdsntd_pkg::ERR_W;
    localparam int BW = rdsntd_pkg::BLOCK_W;
    localparam int NW = rdsntd_pkg::NAME_W;
    localparam int TD = rdsntd_pkg::TEXT_DEPTH;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [EW-1:0] max_err_reg;
    logic [EW-1:0] max_err_next;
    logic          cfg_hit;

    assign cfg_hit = (paddr == rdsntd_pkg::ADDR_MAX_TRUSTED);
    assign pready  = 1'b1;
    assign prdata  = cfg_hit ? {{(rdsntd_pkg::CFG_DW-EW){1'b0}}, max_err_reg} : '0;

    always_comb
    begin
        max_err_next = max_err_reg;
        if (psel && penable && pwrite && pready && cfg_hit)
        begin
            max_err_next = pwdata[EW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_err_reg <= rdsntd_pkg::MAX_TRUSTED_RESET;
        end
        else
        begin
            max_err_reg <= max_err_next;
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // ------------------------------------------------------------------
    logic a_valid_reg, a_valid_next;
    logic b_valid_reg, b_valid_next;
    logic out_valid_reg, out_valid_next;
    logic out_free, adv, a_issue, b_move, a_fin;

    assign out_free = !out_valid_reg || res.ready;
    assign adv      = !b_valid_reg || out_free;
    assign a_issue  = a_valid_reg && adv;
    assign b_move   = b_valid_reg && out_free;
    assign grp.ready = !a_valid_reg || (a_issue && a_fin);

    // ------------------------------------------------------------------
    // Issue stage: holds one group and walks its letters
    // ------------------------------------------------------------------
    logic          a_mode_reg, a_rdy_reg;
    logic [BW-1:0] a_b_reg, a_c_reg, a_d_reg;
    logic [EW-1:0] a_eb_reg, a_ec_reg, a_ed_reg;
    logic [1:0]    k_reg, k_next;

    logic          ok_b, ok_c, ok_d, ver_b, is_group, is_name, is_text, has_letters;
    logic [3:0]    kind;
    logic [1:0]    let_idx;
    logic [7:0]    let_raw;
    logic [CW-1:0] let_shown;
    logic [AW-1:0] let_place;
    logic          last_k;
    rdsntd_pkg::seq_op_t a_op;

    logic          b_we;
    logic [AW-1:0] b_waddr;
    logic [CW-1:0] b_wdata;
    logic [CW-1:0] ram_rdata;

    // Group decode against the trusted error class.
    always_comb
    begin
        ok_b        = a_eb_reg <= max_err_reg;
        ok_c        = a_ec_reg <= max_err_reg;
        ok_d        = a_ed_reg <= max_err_reg;
        kind        = a_b_reg[15:12];
        ver_b       = (a_b_reg & rdsntd_pkg::VER_B_MASK) != '0;
        is_group    = !a_mode_reg && a_rdy_reg && ok_b;
        is_name     = is_group && (kind == rdsntd_pkg::GRP_NAME) && ok_d;
        is_text     = is_group && (kind == rdsntd_pkg::GRP_TEXT);
        has_letters = is_text && ok_d && (ver_b || ok_c);
    end

    // Current letter: version B takes only the two letters of block D.
    always_comb
    begin
        let_idx = ver_b ? {1'b1, k_reg[0]} : k_reg;
        case (let_idx)
            2'd0:    let_raw = a_c_reg[15:8];
            2'd1:    let_raw = a_c_reg[7:0];
            2'd2:    let_raw = a_d_reg[15:8];
            default: let_raw = a_d_reg[7:0];
        endcase
        let_shown = rdsntd_pkg::text_char(let_raw);
        let_place = ver_b ? {1'b0, a_b_reg[3:0], k_reg[0]} : {a_b_reg[3:0], k_reg};
        last_k    = ver_b ? k_reg[0] : (k_reg == 2'd3);
        a_fin     = !has_letters || last_k || (let_shown == '0);
    end

    // Step descriptor, with forwarding of a write to the address being read.
    always_comb
    begin
        a_op.first    = (k_reg == 2'd0);
        a_op.fin      = a_fin;
        a_op.clear    = a_mode_reg;
        a_op.name_upd = is_name;
        a_op.seg      = a_b_reg[1:0];
        a_op.name_hi  = rdsntd_pkg::to_print(a_d_reg[15:8]);
        a_op.name_lo  = rdsntd_pkg::to_print(a_d_reg[7:0]);
        a_op.text_grp = is_text;
        a_op.ab_flag  = a_b_reg[4];
        a_op.letter   = has_letters;
        a_op.place    = let_place;
        a_op.shown    = let_shown;
        a_op.fwd      = b_we && (b_waddr == let_place);
        a_op.fwd_val  = b_wdata;
    end

    always_comb
    begin
        a_valid_next = a_valid_reg;
        k_next       = k_reg;
        if (a_issue)
        begin
            k_next = a_fin ? 2'd0 : k_reg + 2'd1;
            if (a_fin)
            begin
                a_valid_next = 1'b0;
            end
        end
        if (grp.valid && grp.ready)
        begin
            a_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            k_reg       <= 2'd0;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            k_reg       <= k_next;
        end
    end

    // Group payload is captured on acceptance.
    always_ff @(posedge clk)
    begin
        if (grp.valid && grp.ready)
        begin
            a_mode_reg <= grp.mode;
            a_rdy_reg  <= grp.group_ready;
            a_b_reg    <= grp.block_b;
            a_c_reg    <= grp.block_c;
            a_d_reg    <= grp.block_d;
            a_eb_reg   <= grp.errors_b;
            a_ec_reg   <= grp.errors_c;
            a_ed_reg   <= grp.errors_d;
        end
    end

    // ------------------------------------------------------------------
    // Text memory
    // ------------------------------------------------------------------
    rdsntd_ram #(
        .WIDTH (CW),
        .DEPTH (TD)
    ) u_text_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .re    (a_issue && has_letters),
        .raddr (let_place),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Update stage: read-modify-write of the text and the name state
    // ------------------------------------------------------------------
    rdsntd_pkg::seq_op_t b_op_reg;

    logic [NW-1:0] shown_reg, shown_next;
    logic [3:0]    seen_reg, seen_next;
    logic          ab_reg, ab_next;
    logic [TD-1:0] written_reg, written_next;
    logic          pos0_nz_reg, pos0_nz_next;
    logic          texted_reg, texted_next;
    logic [7:0]    pend_reg [rdsntd_pkg::NAME_CHARS];
    logic [7:0]    pend_next [rdsntd_pkg::NAME_CHARS];

    logic          flip, wipe, diff, texted_now, full, named;
    logic [TD-1:0] written_base;
    logic [CW-1:0] old_store, old_val;
    logic [3:0]    seen_or;
    logic [NW-1:0] name_word;

    assign b_we    = b_move && b_op_reg.letter;
    assign b_waddr = b_op_reg.place;
    assign b_wdata = b_op_reg.shown;

    // Flip, clear and letter compare.
    always_comb
    begin
        flip         = b_op_reg.text_grp && b_op_reg.first && (b_op_reg.ab_flag != ab_reg);
        wipe         = b_op_reg.first && (b_op_reg.clear || flip);
        written_base = wipe ? '0 : written_reg;
        old_store    = b_op_reg.fwd ? b_op_reg.fwd_val : ram_rdata;
        old_val      = written_base[b_op_reg.place] ? old_store : '0;
        diff         = b_op_reg.letter && (old_val != b_op_reg.shown);
        texted_now   = (b_op_reg.first ? (flip && pos0_nz_reg) : texted_reg) || diff;
    end

    // Pending name update and publish check.
    always_comb
    begin
        for (int i = 0; i < rdsntd_pkg::NAME_CHARS; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        if (b_op_reg.name_upd)
        begin
            pend_next[{b_op_reg.seg, 1'b0}] = b_op_reg.name_hi;
            pend_next[{b_op_reg.seg, 1'b1}] = b_op_reg.name_lo;
        end
        for (int i = 0; i < rdsntd_pkg::NAME_CHARS; i++)
        begin
            name_word[NW-1-8*i -: 8] = pend_next[i];
        end
        seen_or = seen_reg | (4'b0001 << b_op_reg.seg);
        full    = b_op_reg.name_upd && (seen_or == rdsntd_pkg::SEG_ALL);
        named   = full && (name_word != shown_reg);
    end

    // Next state, committed when the step moves into the output register.
    always_comb
    begin
        shown_next   = shown_reg;
        seen_next    = seen_reg;
        ab_next      = ab_reg;
        written_next = written_reg;
        pos0_nz_next = pos0_nz_reg;
        texted_next  = texted_reg;
        if (b_move)
        begin
            texted_next  = texted_now;
            written_next = written_base;
            if (wipe)
            begin
                pos0_nz_next = 1'b0;
            end
            if (flip)
            begin
                ab_next = b_op_reg.ab_flag;
            end
            if (b_op_reg.clear)
            begin
                shown_next = '0;
                seen_next  = '0;
            end
            if (b_op_reg.name_upd)
            begin
                seen_next = full ? 4'h0 : seen_or;
            end
            if (named)
            begin
                shown_next = name_word;
            end
            if (b_op_reg.letter)
            begin
                written_next[b_op_reg.place] = 1'b1;
                if (b_op_reg.place == '0)
                begin
                    pos0_nz_next = (b_op_reg.shown != '0);
                end
            end
        end
    end

    assign b_valid_next = a_issue ? 1'b1 : (b_move ? 1'b0 : b_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            shown_reg   <= '0;
            seen_reg    <= '0;
            ab_reg      <= 1'b0;
            written_reg <= '0;
            pos0_nz_reg <= 1'b0;
            texted_reg  <= 1'b0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            shown_reg   <= shown_next;
            seen_reg    <= seen_next;
            ab_reg      <= ab_next;
            written_reg <= written_next;
            pos0_nz_reg <= pos0_nz_next;
            texted_reg  <= texted_next;
        end
    end

    // Step payload and pending name letters.
    always_ff @(posedge clk)
    begin
        if (a_issue)
        begin
            b_op_reg <= a_op;
        end
        if (b_move)
        begin
            for (int i = 0; i < rdsntd_pkg::NAME_CHARS; i++)
            begin
                pend_reg[i] <= pend_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [NW-1:0] o_name_reg;
    logic          o_named_reg, o_texted_reg, o_letter_reg, o_last_reg;
    logic [AW-1:0] o_pos_reg;
    logic [CW-1:0] o_val_reg;

    assign out_valid_next = b_move ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_move)
        begin
            o_name_reg   <= shown_next;
            o_named_reg  <= named;
            o_texted_reg <= b_op_reg.fin && texted_now;
            o_letter_reg <= b_op_reg.letter;
            o_pos_reg    <= b_op_reg.letter ? b_op_reg.place : '0;
            o_val_reg    <= b_op_reg.letter ? b_op_reg.shown : '0;
            o_last_reg   <= b_op_reg.fin;
        end
    end

    assign res.valid           = out_valid_reg;
    assign res.station_name    = o_name_reg;
    assign res.name_changed    = o_named_reg;
    assign res.text_changed    = o_texted_reg;
    assign res.letter_valid    = o_letter_reg;
    assign res.letter_position = o_pos_reg;
    assign res.letter_value    = o_val_reg;
    assign res.last            = o_last_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RDSNTD_ASSERT_SAME(a_pos0_marked, pos0_nz_reg, written_reg[0], "position 0 shadow without valid mark")
    `RDSNTD_ASSERT_NEXT(a_write_marks, b_we, written_reg[$past(b_op_reg.place)], "written letter not marked valid")
    `RDSNTD_ASSERT_SAME(a_mid_is_letter, out_valid_reg && !o_last_reg, o_letter_reg, "non-final result without a letter")
    `RDSNTD_ASSERT_SAME(a_two_letter_count, a_valid_reg && has_letters && ver_b, !k_reg[1], "version B group counted past two letters")
    `RDSNTD_ASSERT_NEXT(a_stall_holds, b_valid_reg && !out_free, b_valid_reg && $stable(b_op_reg), "update stage lost its step while stalled")

endmodule

[verif/tb_rds_name_and_text_decoder.sv]
// Testbench for the RDS station name and radio text decoder: predicts every result item
// from accepted groups and compares it field by field under random stalls on both channels.
// Depends on rdsntd_pkg, rdsntd_if and the rds_name_and_text_decoder RTL.
`timescale 1ns / 1ps

module tb_rds_name_and_text_decoder;
    import rdsntd_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 10;
    localparam int PHASE_ITEMS    = 100;
    localparam int IDLE_PERCENT   = 19;
    localparam logic [NAME_W-1:0] START_NAME = "RDS  FM ";

    typedef struct packed {
        logic               mode;
        logic               group_ready;
        logic [BLOCK_W-1:0] block_b;
        logic [BLOCK_W-1:0] block_c;
        logic [BLOCK_W-1:0] block_d;
        logic [ERR_W-1:0]   errors_b;
        logic [ERR_W-1:0]   errors_c;
        logic [ERR_W-1:0]   errors_d;
    } rds_group_t;

    typedef struct packed {
        logic [NAME_W-1:0]  station_name;
        logic               name_changed;
        logic               text_changed;
        logic               letter_valid;
        logic [TEXT_AW-1:0] letter_position;
        logic [CHAR_W-1:0]  letter_value;
        logic               last;
    } rds_result_t;

    // Tracks the shown name and radio text and keeps the results still due from the block.
    class rds_display_tracker;
        logic [ERR_W-1:0]      max_trusted = MAX_TRUSTED_RESET;
        logic [7:0]            pending_name [NAME_CHARS];
        logic [NAME_W-1:0]     shown_name = '0;
        logic [3:0]            segments_seen = '0;
        logic                  ab_flag = 1'b0;
        logic [CHAR_W-1:0]     text_store [TEXT_DEPTH];
        logic [TEXT_DEPTH-1:0] text_written = '0;
        rds_result_t           due_results [$];
        int unsigned           mismatches = 0;

        function logic trusted(logic [ERR_W-1:0] err);
            return err <= max_trusted;
        endfunction

        function logic [7:0] printable(logic [7:0] ch);
            return (ch >= CHAR_SPACE && ch < CHAR_DEL) ? ch : CHAR_SPACE;
        endfunction

        // Unwritten positions read as zero.
        function logic [CHAR_W-1:0] text_at(logic [TEXT_AW-1:0] pos);
            return text_written[pos] ? text_store[pos] : '0;
        endfunction

        // Applies one accepted group and queues the results it causes.
        function void note_group(rds_group_t g);
            logic               named;
            logic               texted;
            logic [TEXT_AW-1:0] pos_list [4];
            logic [CHAR_W-1:0]  val_list [4];
            int                 nres;
            int                 count;
            int                 first_idx;
            int                 k;
            logic [1:0]         seg;
            logic [NAME_W-1:0]  full_name;
            logic [7:0]         letters [4];
            logic [7:0]         pc;
            logic [TEXT_AW-1:0] place;
            logic [CHAR_W-1:0]  shown;
            rds_result_t        r;

            named = 1'b0;
            texted = 1'b0;
            nres = 0;
            if (g.mode)
            begin
                // Retune: name and text are dropped, A/B flag and pending letters stay.
                shown_name = '0;
                text_written = '0;
                segments_seen = '0;
            end
            else if (g.group_ready && trusted(g.errors_b))
            begin
                if (g.block_b[15:12] == GRP_NAME && trusted(g.errors_d))
                begin
                    seg = g.block_b[1:0];
                    pending_name[2 * seg] = printable(g.block_d[15:8]);
                    pending_name[2 * seg + 1] = printable(g.block_d[7:0]);
                    segments_seen[seg] = 1'b1;
                    if (segments_seen == SEG_ALL)
                    begin
                        segments_seen = '0;
                        full_name = '0;
                        for (k = 0; k < NAME_CHARS; k++)
                            full_name = {full_name[NAME_W-9:0], pending_name[k]};
                        if (full_name != shown_name)
                        begin
                            shown_name = full_name;
                            named = 1'b1;
                        end
                    end
                end
                if (g.block_b[15:12] == GRP_TEXT)
                begin
                    // A flip of the A/B flag wipes the text even if no letter follows.
                    if (g.block_b[4] != ab_flag)
                    begin
                        ab_flag = g.block_b[4];
                        texted = (text_at('0) != '0);
                        text_written = '0;
                    end
                    if (trusted(g.errors_d) && ((g.block_b & VER_B_MASK) != '0
                                                || trusted(g.errors_c)))
                    begin
                        count = ((g.block_b & VER_B_MASK) != '0) ? 2 : 4;
                        first_idx = (count == 2) ? 2 : 0;
                        letters[0] = g.block_c[15:8];
                        letters[1] = g.block_c[7:0];
                        letters[2] = g.block_d[15:8];
                        letters[3] = g.block_d[7:0];
                        for (k = 0; k < count; k++)
                        begin
                            place = TEXT_AW'(int'(g.block_b[3:0]) * count + k);
                            pc = printable(letters[first_idx + k]);
                            shown = (letters[first_idx + k] == CHAR_CR) ? '0 : pc[CHAR_W-1:0];
                            if (text_at(place) != shown)
                                texted = 1'b1;
                            text_store[place] = shown;
                            text_written[place] = 1'b1;
                            pos_list[nres] = place;
                            val_list[nres] = shown;
                            nres++;
                            // CR ends the text: the rest of the group is skipped.
                            if (shown == '0)
                                break;
                        end
                    end
                end
            end

            if (nres == 0)
            begin
                r = '{shown_name, named, texted, 1'b0, '0, '0, 1'b1};
                due_results.push_back(r);
            end
            for (k = 0; k < nres; k++)
            begin
                r.station_name = shown_name;
                r.name_changed = named;
                r.text_changed = (k == nres - 1) && texted;
                r.letter_valid = 1'b1;
                r.letter_position = pos_list[k];
                r.letter_value = val_list[k];
                r.last = (k == nres - 1);
                due_results.push_back(r);
            end
        endfunction

        function void compare_field(string field, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
            end
        endfunction

        // Compares one accepted result with the oldest one due.
        function void check_result(rds_result_t got);
            rds_result_t want;
            if (due_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result with none due: expected none, actual %0h", $time, got);
            end
            else
            begin
                want = due_results.pop_front();
                compare_field("station_name", want.station_name, got.station_name);
                compare_field("name_changed", 64'(want.name_changed), 64'(got.name_changed));
                compare_field("text_changed", 64'(want.text_changed), 64'(got.text_changed));
                compare_field("letter_valid", 64'(want.letter_valid), 64'(got.letter_valid));
                compare_field("letter_position", 64'(want.letter_position),
                              64'(got.letter_position));
                compare_field("letter_value", 64'(want.letter_value), 64'(got.letter_value));
                compare_field("last", 64'(want.last), 64'(got.last));
            end
        endfunction
    endclass

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [CFG_AW-1:0] paddr;
    logic [CFG_DW-1:0] pwdata;
    logic [CFG_DW-1:0] prdata;
    logic              pready;

    rdsntd_in_if  grp_ch ();
    rdsntd_out_if res_ch ();

    rds_display_tracker tracker;
    bit                 no_idle;
    bit                 hold_req;
    int unsigned        quiet_cycles;
    logic [7:0]         on_air_name [NAME_CHARS];
    logic               on_air_flag;

    rds_name_and_text_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .grp     (grp_ch),
        .res     (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rds_group_t make_group(logic mode, logic rdy, logic [15:0] b,
                                              logic [15:0] c, logic [15:0] d,
                                              logic [1:0] eb, logic [1:0] ec, logic [1:0] ed);
        rds_group_t g;
        g = '{mode, rdy, b, c, d, eb, ec, ed};
        return g;
    endfunction

    // Mostly printable letters, some CR and some raw bytes.
    function automatic logic [7:0] rand_char();
        int pick;
        pick = $urandom_range(99);
        if (pick < 85)
            return 8'($urandom_range(32, 126));
        else if (pick < 92)
            return CHAR_CR;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [1:0] rand_err();
        return ($urandom_range(9) < 6) ? 2'd0 : 2'($urandom_range(3));
    endfunction

    // Well-formed name and text groups of a simulated station, plus clears and noise.
    function automatic rds_group_t rand_group();
        rds_group_t g;
        int         pick;
        int         seg;
        g = make_group(1'b0, 1'b1, 16'($urandom_range(16'hFFFF)),
                       16'($urandom_range(16'hFFFF)), 16'($urandom_range(16'hFFFF)),
                       rand_err(), rand_err(), rand_err());
        pick = $urandom_range(99);
        if (pick < 4)
            g.mode = 1'b1;
        else if (pick < 9)
            g.group_ready = 1'b0;
        else if (pick < 45)
        begin
            if ($urandom_range(9) == 0)
                on_air_name[$urandom_range(NAME_CHARS - 1)] = rand_char();
            seg = $urandom_range(3);
            g.block_b[15:12] = GRP_NAME;
            g.block_b[1:0] = 2'(seg);
            g.block_d = {on_air_name[2 * seg], on_air_name[2 * seg + 1]};
        end
        else if (pick < 88)
        begin
            if ($urandom_range(19) == 0)
                on_air_flag = ~on_air_flag;
            g.block_b[15:12] = GRP_TEXT;
            g.block_b[4] = on_air_flag;
            g.block_c = {rand_char(), rand_char()};
            g.block_d = {rand_char(), rand_char()};
        end
        return g;
    endfunction

    // Offers one group, after random idle cycles, and holds it until it is taken.
    task automatic send_group(rds_group_t g);
        while (!no_idle && $urandom_range(99) < IDLE_PERCENT)
        begin
            grp_ch.valid <= 1'b0;
            @(posedge clk);
        end
        grp_ch.valid       <= 1'b1;
        grp_ch.mode        <= g.mode;
        grp_ch.group_ready <= g.group_ready;
        grp_ch.block_b     <= g.block_b;
        grp_ch.block_c     <= g.block_c;
        grp_ch.block_d     <= g.block_d;
        grp_ch.errors_b    <= g.errors_b;
        grp_ch.errors_c    <= g.errors_c;
        grp_ch.errors_d    <= g.errors_d;
        do @(posedge clk); while (!grp_ch.ready);
    endtask

    task automatic drain_results();
        grp_ch.valid <= 1'b0;
        do @(posedge clk); while (tracker.due_results.size() != 0);
    endtask

    // Changes the trust level once the block has gone idle.
    task automatic set_max_trusted(logic [ERR_W-1:0] level);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_TRUSTED;
        pwdata  <= CFG_DW'(level);
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.max_trusted = level;
    endtask

    task automatic run_random(int count);
        int n;
        for (n = 0; n < count; n++)
            send_group(rand_group());
    endtask

    // Receiver: random stalls, one long hold-off on request.
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Handshake monitor on both channels.
    always @(posedge clk)
    begin
        rds_group_t  g_seen;
        rds_result_t r_seen;
        if (rst_n)
        begin
            if (grp_ch.valid && grp_ch.ready)
            begin
                g_seen = '{grp_ch.mode, grp_ch.group_ready, grp_ch.block_b, grp_ch.block_c,
                           grp_ch.block_d, grp_ch.errors_b, grp_ch.errors_c, grp_ch.errors_d};
                tracker.note_group(g_seen);
            end
            if (res_ch.valid && res_ch.ready)
            begin
                r_seen = '{res_ch.station_name, res_ch.name_changed, res_ch.text_changed,
                           res_ch.letter_valid, res_ch.letter_position, res_ch.letter_value,
                           res_ch.last};
                tracker.check_result(r_seen);
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if ((grp_ch.valid && grp_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int k;
        tracker = new;
        no_idle = 1'b0;
        hold_req = 1'b0;
        quiet_cycles = 0;
        on_air_flag = 1'b0;
        for (k = 0; k < NAME_CHARS; k++)
            on_air_name[k] = START_NAME[8 * (NAME_CHARS - 1 - k) +: 8];
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        grp_ch.valid = 1'b0;
        grp_ch.mode = 1'b0;
        grp_ch.group_ready = 1'b0;
        grp_ch.block_b = '0;
        grp_ch.block_c = '0;
        grp_ch.block_d = '0;
        grp_ch.errors_b = '0;
        grp_ch.errors_c = '0;
        grp_ch.errors_d = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset trust level of one.
        send_group(make_group(1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 2'd3, 2'd3));
        send_group(make_group(1'b0, 1'b1, 16'h0000, 16'h0000, "RA", 2'd0, 2'd0, 2'd0));
        send_group(make_group(1'b0, 1'b1, 16'h0001, 16'h0000, "DI", 2'd1, 2'd0, 2'd1));
        send_group(make_group(1'b0, 1'b1, 16'h0002, 16'h0000, "O ", 2'd0, 2'd3, 2'd0));
        send_group(make_group(1'b0, 1'b1, 16'h07FF, 16'h0000, "1!", 2'd0, 2'd0, 2'd0));
        // Same name again: complete but unchanged.
        send_group(make_group(1'b0, 1'b1, 16'h0003, 16'h0000, "1!", 2'd0, 2'd0, 2'd0));
        send_group(make_group(1'b0, 1'b1, 16'h0000, 16'h0000, "RA", 2'd0, 2'd0, 2'd0));
        send_group(make_group(1'b0, 1'b1, 16'h0002, 16'h0000, "O ", 2'd0, 2'd0, 2'd0));
        send_group(make_group(1'b0, 1'b1, 16'h0001, 16'h0000, "DI", 2'd0, 2'd0, 2'd0));
        // Untrusted D on a name group, then unprintable name letters.
        send_group(make_group(1'b0, 1'b1, 16'h0001, 16'h0000, 16'h00FF, 2'd0, 2'd0, 2'd2));
        send_group(make_group(1'b0, 1'b1, 16'h0001, 16'h0000, 16'h7F1F, 2'd0, 2'd0, 2'd0));
        // Radio text: version A, rewrite of the same letters, version B at the top segment.
        send_group(make_group(1'b0, 1'b1, 16'h2000, "He", "ll", 2'd0, 2'd0, 2'd0));
        send_group(make_group(1'b0, 1'b1, 16'h2000, "He", "ll", 2'd0, 2'd1, 2'd1));
        send_group(make_group(1'b0, 1'b1, 16'h280F, 16'hFFFF, "o!", 2'd0, 2'd3, 2'd0));
        // CR in the first letter ends the group early.
        send_group(make_group(1'b0, 1'b1, 16'h200F, 16'h0D41, "BC", 2'd0, 2'd0, 2'd0));
        send_group(make_group(1'b0, 1'b1, 16'h2001, 16'h7F00, 16'hFFE9, 2'd0, 2'd0, 2'd0));
        // Untrusted C in version A: no letters.
        send_group(make_group(1'b0, 1'b1, 16'h2002, "xy", "zw", 2'd0, 2'd2, 2'd0));
        // A/B flip with untrusted D still wipes the text.
        send_group(make_group(1'b0, 1'b1, 16'h2010, "ab", "cd", 2'd0, 2'd0, 2'd3));
        // Untrusted B hides the flip back.
        send_group(make_group(1'b0, 1'b1, 16'h2000, "ab", "cd", 2'd2, 2'd0, 2'd0));
        send_group(make_group(1'b0, 1'b1, 16'hF123, "ab", "cd", 2'd0, 2'd0, 2'd0));
        send_group(make_group(1'b0, 1'b1, 16'h2010, 16'h0D00, "cd", 2'd0, 2'd0, 2'd0));
        send_group(make_group(1'b1, 1'b1, 16'h2000, "ab", "cd", 2'd0, 2'd0, 2'd0));
        send_group(make_group(1'b1, 1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 2'd3, 2'd3, 2'd3));

        // Highest trust level: worst error classes are accepted.
        set_max_trusted(2'd3);
        send_group(make_group(1'b0, 1'b1, 16'h2A15, "no", "ok", 2'd3, 2'd3, 2'd3));
        send_group(make_group(1'b0, 1'b1, 16'h0000, 16'h0000, "ZZ", 2'd3, 2'd3, 2'd3));
        run_random(PHASE_ITEMS);

        // Lowest trust level, first part without any stalls.
        set_max_trusted(2'd0);
        no_idle = 1'b1;
        run_random(PHASE_ITEMS / 2);
        no_idle = 1'b0;
        run_random(PHASE_ITEMS / 2);

        // Receiver holds off while groups keep coming.
        set_max_trusted(2'd2);
        hold_req = 1'b1;
        run_random(PHASE_ITEMS);

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.due_results.size() != 0)
            $display("%0t: results still due: expected 0, actual %0d",
                     $time, tracker.due_results.size());
        if (tracker.mismatches == 0 && tracker.due_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
